>>> rtl/der_tlv_stream_reader_macros.svh
`ifndef DER_TLV_STREAM_READER_MACROS_SVH
`define DER_TLV_STREAM_READER_MACROS_SVH

// Check a property on every clock, held off during reset.
`define DTSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define DTSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define DTSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dtsr_pkg.sv
package dtsr_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int LEN_OUT_W   = 24;
  localparam int MAX_NB      = LENGTH_BITS / 8;
  localparam logic [1:0] MAX_LEN_RST = 2'd3;
  localparam logic [7:0] LONG_FORM_BIT = 8'h80;
  localparam logic [7:0] NB_MASK       = 8'h7f;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN1    = 5'b00010,
    PH_LENX    = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_TAG     = 2'd0,
    ROLE_LEN     = 2'd1,
    ROLE_CONTENT = 2'd2,
    ROLE_IGNORED = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNC_HDR = 2'd1,
    ERR_BAD_LEN   = 2'd2,
    ERR_OVERRUN   = 2'd3
  } err_t;

  typedef struct packed {
    phase_t                 phase;
    logic [7:0]             tag;
    logic [1:0]             len_left;
    logic [LENGTH_BITS-1:0] accum;
    logic [LENGTH_BITS-1:0] content_left;
  } state_t;

  typedef struct packed {
    role_t                byte_role;
    logic [7:0]           element_tag;
    logic [LEN_OUT_W-1:0] element_length;
    logic                 header_done;
    logic [7:0]           content_byte;
    logic                 element_end;
    err_t                 error_code;
  } res_t;

  function automatic logic [LEN_OUT_W-1:0] len_to_out(input logic [LENGTH_BITS-1:0] v);
    logic [LENGTH_BITS+LEN_OUT_W-1:0] tmp;
    tmp = (LENGTH_BITS + LEN_OUT_W)'(v);
    return tmp[LEN_OUT_W-1:0];
  endfunction

endpackage

>>> rtl/dtsr_in_if.sv
interface dtsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/dtsr_out_if.sv
interface dtsr_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      byte_role;
  logic [7:0]                      element_tag;
  logic [dtsr_pkg::LEN_OUT_W-1:0]  element_length;
  logic                            header_done;
  logic [7:0]                      content_byte;
  logic                            element_end;
  logic [1:0]                      error_code;

  modport source (output valid, output byte_role, output element_tag,
                  output element_length, output header_done, output content_byte,
                  output element_end, output error_code, input ready);
  modport sink   (input valid, input byte_role, input element_tag,
                  input element_length, input header_done, input content_byte,
                  input element_end, input error_code, output ready);
endinterface

>>> rtl/dtsr_step.sv
module dtsr_step (
  input  dtsr_pkg::state_t st,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [1:0]       max_len,
  output dtsr_pkg::state_t st_nxt,
  output dtsr_pkg::res_t   res
);
  import dtsr_pkg::*;

  logic [7:0]             nb;
  logic                   nb_bad;
  logic [LENGTH_BITS-1:0] accum_sh;
  logic [1:0]             left_dec;
  logic [LENGTH_BITS-1:0] cont_dec;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic                   hdr_fire;

  assign nb       = data_byte & NB_MASK;
  assign nb_bad   = (nb == 8'd0) || (nb > {6'd0, max_len}) || (32'(nb) > MAX_NB);
  assign accum_sh = LENGTH_BITS'({st.accum, data_byte});
  assign left_dec = st.len_left - 2'd1;
  assign cont_dec = st.content_left - LENGTH_BITS'(1);

  always_comb begin
    st_nxt   = st;
    res      = '0;
    hdr_fire = 1'b0;
    hdr_len  = '0;
    res.element_tag = st.tag;
    case (st.phase)
      PH_TAG: begin
        res.byte_role   = ROLE_TAG;
        res.element_tag = data_byte;
        st_nxt.tag      = data_byte;
        st_nxt.accum    = '0;
        if (last_byte) begin
          res.error_code = ERR_TRUNC_HDR;
          st_nxt.phase   = PH_TAG;
        end else begin
          st_nxt.phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        res.byte_role = ROLE_LEN;
        if ((data_byte & LONG_FORM_BIT) != 8'd0) begin
          if (nb_bad) begin
            res.error_code = ERR_BAD_LEN;
            st_nxt.phase   = last_byte ? PH_TAG : PH_SKIP;
          end else if (last_byte) begin
            res.error_code = ERR_TRUNC_HDR;
            st_nxt.phase   = PH_TAG;
          end else begin
            st_nxt.len_left = nb[1:0];
            st_nxt.accum    = '0;
            st_nxt.phase    = PH_LENX;
          end
        end else begin
          hdr_fire = 1'b1;
          hdr_len  = LENGTH_BITS'({1'b0, data_byte});
        end
      end
      PH_LENX: begin
        res.byte_role   = ROLE_LEN;
        st_nxt.accum    = accum_sh;
        st_nxt.len_left = left_dec;
        if (left_dec == 2'd0) begin
          hdr_fire = 1'b1;
          hdr_len  = accum_sh;
        end else if (last_byte) begin
          res.error_code = ERR_TRUNC_HDR;
          st_nxt.phase   = PH_TAG;
        end
      end
      PH_CONTENT: begin
        res.byte_role       = ROLE_CONTENT;
        res.content_byte    = data_byte;
        res.element_length  = len_to_out(st.accum);
        st_nxt.content_left = cont_dec;
        if (cont_dec == '0) begin
          res.element_end = 1'b1;
          st_nxt.phase    = PH_TAG;
        end else if (last_byte) begin
          res.error_code = ERR_OVERRUN;
          st_nxt.phase   = PH_TAG;
        end
      end
      default: begin
        res.byte_role = ROLE_IGNORED;
        st_nxt.phase  = last_byte ? PH_TAG : PH_SKIP;
      end
    endcase

    if (hdr_fire) begin
      st_nxt.accum       = hdr_len;
      res.header_done    = 1'b1;
      res.element_length = len_to_out(hdr_len);
      if (hdr_len == '0) begin
        res.element_end = 1'b1;
        st_nxt.phase    = PH_TAG;
      end else if (last_byte) begin
        res.error_code = ERR_OVERRUN;
        st_nxt.phase   = PH_TAG;
      end else begin
        st_nxt.content_left = hdr_len;
        st_nxt.phase        = PH_CONTENT;
      end
    end
  end
endmodule

>>> rtl/der_tlv_stream_reader.sv
// Streaming DER tag-length-value splitter. Bytes of a buffer arrive on in_ch,
// one per request, with last_byte on the final byte; every byte gives exactly
// one result request on out_ch carrying its role (tag, length, content or
// ignored), the current tag and length, the content byte, header and element
// end flags, and an error code. One byte is taken per clock cycle: the next
// parser state is combinational and each result lands in one output register,
// so a new byte is taken whenever that register is empty or being drained in
// the same cycle. An accepted byte's result is offered in the next cycle.
// cfg_wdata written with cfg_we sets the largest accepted count of long-form
// length bytes (reset 3); write it only while no byte is in flight.
`include "der_tlv_stream_reader_macros.svh"

module der_tlv_stream_reader (
  input  logic              clk,
  input  logic              rst_n,
  dtsr_in_if.sink           in_ch,
  dtsr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata
);
  import dtsr_pkg::*;

  logic       max_len_r;
  logic [1:0] max_len_q_r;
  state_t     st_r;
  state_t     st_nxt;
  res_t       res_r;
  res_t       res_nxt;
  logic       out_valid_r;
  logic       in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  dtsr_step u_step (
    .st        (st_r),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .max_len   (max_len_q_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_q_r <= MAX_LEN_RST;
      max_len_r   <= 1'b0;
    end else if (cfg_we) begin
      max_len_q_r <= cfg_wdata;
      max_len_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{phase: PH_TAG, default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_role      = res_r.byte_role;
  assign out_ch.element_tag    = res_r.element_tag;
  assign out_ch.element_length = res_r.element_length;
  assign out_ch.header_done    = res_r.header_done;
  assign out_ch.content_byte   = res_r.content_byte;
  assign out_ch.element_end    = res_r.element_end;
  assign out_ch.error_code     = res_r.error_code;

  `DTSR_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_r, "accepted byte lost")
  `DTSR_ASSERT_IMP(a_err_restarts, out_valid_r && res_r.error_code != ERR_NONE,
    st_r.phase == PH_TAG || st_r.phase == PH_SKIP, "error did not stop parsing")
  `DTSR_ASSERT_IMP(a_hdr_on_len, out_valid_r && res_r.header_done,
    res_r.byte_role == ROLE_LEN, "header done on non-length byte")
  `DTSR_ASSERT_IMP(a_end_role, out_valid_r && res_r.element_end,
    res_r.byte_role == ROLE_LEN || res_r.byte_role == ROLE_CONTENT,
    "element end on wrong role")
  `DTSR_ASSERT_NEXT(a_cfg_held, !cfg_we && max_len_r, $stable(max_len_q_r),
    "length limit changed without write")
endmodule
